[rtl/pbsc_pkg.sv]
// Package: types, codes and constants for the power button supply controller.
`timescale 1ns / 1ps
`default_nettype none
package pbsc_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned BANDGAP_W   = 12;
  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned SUM_W       = 13;
  localparam int unsigned SCNT_W      = 4;
  localparam int unsigned AVG_SHIFT   = 3;
  localparam int unsigned AVG_W       = SUM_W - AVG_SHIFT;
  localparam int unsigned SCALE_SHIFT = 10;
  localparam int unsigned DVD_W       = BANDGAP_W + SCALE_SHIFT;
  localparam int unsigned DIV_CNT_W   = 5;
  localparam int unsigned VOLT_W      = 16;

  localparam logic [SCNT_W-1:0] SAMPLES_DROPPED = 4'd2;
  localparam logic [SCNT_W-1:0] SAMPLES_BURST   = 4'd10;

  localparam logic [CNT_W-1:0] WAKE_HOLD_RST  = 16'd180;
  localparam logic [CNT_W-1:0] OFF_HOLD_RST   = 16'd1900;
  localparam logic [CNT_W-1:0] SETTLE_RST     = 16'd10;
  localparam logic [CNT_W-1:0] OFF_DELAY_RST  = 16'd600;
  localparam logic [BANDGAP_W-1:0] BANDGAP_RST = 12'd1190;

  localparam logic [CFG_INDEX_W-1:0] REG_WAKE_HOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_HOLD  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_DELAY = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BANDGAP   = 3'd4;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CMD    = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic [7:0] CMD_VOLTAGE  = 8'h58;
  localparam logic [7:0] CMD_CHARGE   = 8'h59;
  localparam logic [7:0] CMD_POWEROFF = 8'h6a;

  typedef enum logic [1:0] {
    MODE_SETTLE = 2'd0,
    MODE_ASLEEP = 2'd1,
    MODE_ACTIVE = 2'd2,
    MODE_OFFDLY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_HI   = 2'd2,
    ST_LO   = 2'd3
  } state_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic                key_pressed;
    logic                charging;
    logic [7:0]          rx_byte;
    logic [SAMPLE_W-1:0] sample;
  } in_req_t;

  typedef struct packed {
    logic       power_enable;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       adc_burst_start;
    logic       last;
  } out_req_t;

endpackage
`default_nettype wire

[rtl/power_button_supply_controller.sv]
// Top level: power button supply controller with a shared bit-serial divider.
// Any request but the tenth sample of a burst gives its result in the cycle after it
// is taken. The tenth sample of a burst runs the divider (one quotient bit per cycle),
// then gives the high and then the low voltage byte as two results.
// No request is taken while a result is due; in_ready stays low through a voltage reply.
// Reset (rst_n low, synchronous): default registers, settle mode, all counts cleared.
`timescale 1ns / 1ps
`default_nettype none
module power_button_supply_controller
  import pbsc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_req_t                in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_req_t                    out_data,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  logic [CNT_W-1:0]     wake_hold_r, off_hold_r, settle_r, off_delay_r;
  logic [BANDGAP_W-1:0] bandgap_r;

  logic [CNT_W-1:0]  tick_cnt_r, tick_cnt_nxt;
  logic              key_held_r, key_held_nxt;
  logic [SCNT_W-1:0] smp_cnt_r, smp_cnt_nxt;
  logic [SUM_W-1:0]  smp_sum_r, smp_sum_nxt;
  logic              busy_r, busy_nxt;
  logic              volt_pend_r, volt_pend_nxt;
  logic              chg_pend_r, chg_pend_nxt;

  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [AVG_W-1:0]     rem_r, rem_nxt;
  logic [AVG_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 again_r, again_nxt;
  logic [7:0]           volt_lo_r, volt_lo_nxt;
  out_req_t             out_r, out_nxt;

  logic              in_fire, out_fire;
  logic              go_div, div_done;
  logic [CNT_W-1:0]  tick_bump;
  logic [SCNT_W-1:0] smp_cnt_inc;
  logic [SUM_W-1:0]  smp_sum_upd;
  logic              pwr_down;
  logic              txv;
  logic [7:0]        txb;
  logic              burst;
  logic [AVG_W:0]    rem_sh;
  logic              q_bit;
  logic [DVD_W-1:0]  quo;
  logic [VOLT_W-1:0] volt;
  logic              pe_nxt, pe_cur;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign out_data = out_r;

  assign tick_bump   = (tick_cnt_r != {CNT_W{1'b1}}) ? tick_cnt_r + 1'b1 : tick_cnt_r;
  assign smp_cnt_inc = smp_cnt_r + 1'b1;
  assign smp_sum_upd = (smp_cnt_inc > SAMPLES_DROPPED) ?
                       smp_sum_r + SUM_W'(in_data.sample) : smp_sum_r;

  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign q_bit    = (rem_sh >= {1'b0, dvs_r});
  assign quo      = {dvd_r[DVD_W-2:0], q_bit};
  assign div_done = (state_r == ST_DIV) && (div_cnt_r == '0);
  assign volt     = (|quo[DVD_W-1:VOLT_W]) ? {VOLT_W{1'b1}} : quo[VOLT_W-1:0];
  assign pe_cur   = (mode_r == MODE_ACTIVE) || (mode_r == MODE_OFFDLY);
  assign pe_nxt   = (mode_nxt == MODE_ACTIVE) || (mode_nxt == MODE_OFFDLY);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = go_div ? ST_DIV : ST_LO;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_HI;
        end
      end
      ST_HI: begin
        if (out_fire) begin
          state_nxt = ST_LO;
        end
      end
      ST_LO: begin
        if (out_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_HI:   out_valid = 1'b1;
      ST_LO:   out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_nxt      = mode_r;
    tick_cnt_nxt  = tick_cnt_r;
    key_held_nxt  = key_held_r;
    smp_cnt_nxt   = smp_cnt_r;
    smp_sum_nxt   = smp_sum_r;
    busy_nxt      = busy_r;
    volt_pend_nxt = volt_pend_r;
    chg_pend_nxt  = chg_pend_r;
    again_nxt     = again_r;
    pwr_down      = 1'b0;
    go_div        = 1'b0;
    txv           = 1'b0;
    txb           = 8'd0;
    burst         = 1'b0;
    if (in_fire) begin
      case (in_data.opcode)
        OP_TICK: begin
          case (mode_r)
            MODE_SETTLE: begin
              tick_cnt_nxt = tick_bump;
              if (tick_bump >= settle_r) begin
                mode_nxt     = MODE_ASLEEP;
                tick_cnt_nxt = '0;
              end
            end
            MODE_ASLEEP: begin
              if (in_data.key_pressed) begin
                key_held_nxt = 1'b1;
                tick_cnt_nxt = tick_bump;
                if (tick_bump >= wake_hold_r) begin
                  mode_nxt     = MODE_ACTIVE;
                  tick_cnt_nxt = '0;
                  key_held_nxt = 1'b0;
                end
              end else if (key_held_r) begin
                pwr_down = 1'b1;
              end
            end
            MODE_ACTIVE: begin
              if (in_data.key_pressed) begin
                tick_cnt_nxt = tick_bump;
                if (tick_bump >= off_hold_r) begin
                  pwr_down = 1'b1;
                end
              end else begin
                tick_cnt_nxt = '0;
                if (chg_pend_r) begin
                  chg_pend_nxt = 1'b0;
                  txv          = 1'b1;
                  txb          = {7'd0, in_data.charging};
                end
              end
            end
            default: begin
              tick_cnt_nxt = tick_bump;
              if (tick_bump >= off_delay_r) begin
                pwr_down = 1'b1;
              end
            end
          endcase
        end
        OP_CMD: begin
          if (mode_r == MODE_ACTIVE) begin
            case (in_data.rx_byte)
              CMD_VOLTAGE: begin
                if (busy_r) begin
                  volt_pend_nxt = 1'b1;
                end else begin
                  busy_nxt    = 1'b1;
                  smp_cnt_nxt = '0;
                  smp_sum_nxt = '0;
                  burst       = 1'b1;
                end
              end
              CMD_CHARGE: chg_pend_nxt = 1'b1;
              CMD_POWEROFF: begin
                if (off_delay_r == '0) begin
                  pwr_down = 1'b1;
                end else begin
                  mode_nxt     = MODE_OFFDLY;
                  tick_cnt_nxt = '0;
                end
              end
              default: begin
                mode_nxt = mode_r;
              end
            endcase
          end
        end
        OP_SAMPLE: begin
          if (busy_r) begin
            smp_cnt_nxt = smp_cnt_inc;
            smp_sum_nxt = smp_sum_upd;
            if (smp_cnt_inc >= SAMPLES_BURST) begin
              go_div      = 1'b1;
              busy_nxt    = 1'b0;
              smp_cnt_nxt = '0;
              smp_sum_nxt = '0;
              again_nxt   = volt_pend_r;
              if (volt_pend_r) begin
                volt_pend_nxt = 1'b0;
                busy_nxt      = 1'b1;
              end
            end
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
      if (pwr_down) begin
        mode_nxt      = (settle_r == '0) ? MODE_ASLEEP : MODE_SETTLE;
        tick_cnt_nxt  = '0;
        key_held_nxt  = 1'b0;
        smp_cnt_nxt   = '0;
        smp_sum_nxt   = '0;
        busy_nxt      = 1'b0;
        volt_pend_nxt = 1'b0;
        chg_pend_nxt  = 1'b0;
      end
    end
  end

  always_comb begin
    dvd_nxt     = dvd_r;
    rem_nxt     = rem_r;
    dvs_nxt     = dvs_r;
    div_cnt_nxt = div_cnt_r;
    volt_lo_nxt = volt_lo_r;
    out_nxt     = out_r;
    if (in_fire) begin
      if (go_div) begin
        dvd_nxt     = {bandgap_r, {SCALE_SHIFT{1'b0}}};
        rem_nxt     = '0;
        dvs_nxt     = smp_sum_upd[SUM_W-1:AVG_SHIFT];
        div_cnt_nxt = DIV_LAST;
      end else begin
        out_nxt.power_enable    = pe_nxt;
        out_nxt.tx_valid        = txv;
        out_nxt.tx_byte         = txb;
        out_nxt.adc_burst_start = burst;
        out_nxt.last            = 1'b1;
      end
    end
    if (state_r == ST_DIV) begin
      dvd_nxt     = quo;
      rem_nxt     = q_bit ? AVG_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[AVG_W-1:0];
      div_cnt_nxt = div_cnt_r - 1'b1;
      if (div_done) begin
        volt_lo_nxt             = volt[7:0];
        out_nxt.power_enable    = pe_cur;
        out_nxt.tx_valid        = 1'b1;
        out_nxt.tx_byte         = volt[VOLT_W-1:8];
        out_nxt.adc_burst_start = 1'b0;
        out_nxt.last            = 1'b0;
      end
    end
    if ((state_r == ST_HI) && out_fire) begin
      out_nxt.power_enable    = pe_cur;
      out_nxt.tx_valid        = 1'b1;
      out_nxt.tx_byte         = volt_lo_r;
      out_nxt.adc_burst_start = again_r;
      out_nxt.last            = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wake_hold_r <= WAKE_HOLD_RST;
      off_hold_r  <= OFF_HOLD_RST;
      settle_r    <= SETTLE_RST;
      off_delay_r <= OFF_DELAY_RST;
      bandgap_r   <= BANDGAP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WAKE_HOLD: wake_hold_r <= cfg_wdata;
        REG_OFF_HOLD:  off_hold_r  <= cfg_wdata;
        REG_SETTLE:    settle_r    <= cfg_wdata;
        REG_OFF_DELAY: off_delay_r <= cfg_wdata;
        REG_BANDGAP:   bandgap_r   <= cfg_wdata[BANDGAP_W-1:0];
        default: begin
          bandgap_r <= bandgap_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_SETTLE;
      tick_cnt_r  <= '0;
      key_held_r  <= 1'b0;
      smp_cnt_r   <= '0;
      smp_sum_r   <= '0;
      busy_r      <= 1'b0;
      volt_pend_r <= 1'b0;
      chg_pend_r  <= 1'b0;
      div_cnt_r   <= '0;
      again_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      key_held_r  <= key_held_nxt;
      smp_cnt_r   <= smp_cnt_nxt;
      smp_sum_r   <= smp_sum_nxt;
      busy_r      <= busy_nxt;
      volt_pend_r <= volt_pend_nxt;
      chg_pend_r  <= chg_pend_nxt;
      div_cnt_r   <= div_cnt_nxt;
      again_r     <= again_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    dvs_r     <= dvs_nxt;
    volt_lo_r <= volt_lo_nxt;
    out_r     <= out_nxt;
  end

endmodule
`default_nettype wire

[sim/tb_power_button_supply_controller.sv]
// Testbench for the power button supply controller: directed and random requests.
`timescale 1ns / 1ps
module tb_power_button_supply_controller;
  import pbsc_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 3;
  localparam int DRAIN_CYCLES = 32;
  localparam int STALL_LIMIT  = 2000;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [7:0] CMD_UNKNOWN = 8'hff;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_req_t                in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_req_t               out_data;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  power_button_supply_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predicted supply state and register copies
  mode_t              m_mode;
  logic [CNT_W-1:0]   m_ticks;
  logic               m_key_held;
  logic [SCNT_W-1:0]  m_scount;
  logic [SUM_W-1:0]   m_ssum;
  logic               m_burst;
  logic               m_volt_req;
  logic               m_chg_req;
  logic [CNT_W-1:0]   r_wake;
  logic [CNT_W-1:0]   r_off_hold;
  logic [CNT_W-1:0]   r_settle;
  logic [CNT_W-1:0]   r_off_delay;
  logic [BANDGAP_W-1:0] r_bandgap;

  out_req_t due_out[$];

  logic steady = 1'b0;
  int   burst_kind = 0;
  int   n_err = 0;
  int   n_sent = 0;
  int   n_results = 0;
  int   n_volt = 0;
  int   n_settings = 0;
  int   stall_cycles = 0;

  task automatic bump_ticks();
    if (m_ticks != 16'hffff) m_ticks++;
  endtask

  task automatic supply_down();
    m_mode     = (r_settle == 16'd0) ? MODE_ASLEEP : MODE_SETTLE;
    m_ticks    = '0;
    m_key_held = 1'b0;
    m_scount   = '0;
    m_ssum     = '0;
    m_burst    = 1'b0;
    m_volt_req = 1'b0;
    m_chg_req  = 1'b0;
  endtask

  task automatic begin_burst();
    m_burst  = 1'b1;
    m_scount = '0;
    m_ssum   = '0;
  endtask

  task automatic push_out(input logic txv, input logic [7:0] txb, input logic bst,
                          input logic lst);
    out_req_t o;
    o.power_enable    = (m_mode == MODE_ACTIVE) || (m_mode == MODE_OFFDLY);
    o.tx_valid        = txv;
    o.tx_byte         = txv ? txb : 8'h00;
    o.adc_burst_start = bst;
    o.last            = lst;
    due_out.push_back(o);
  endtask

  task automatic predict_supply(input in_req_t r);
    logic                 txv;
    logic [7:0]           txb;
    logic                 bst;
    logic                 again;
    logic [AVG_W-1:0]     avg;
    logic [31:0]          quo;
    logic [VOLT_W-1:0]    volt;
    txv = 1'b0;
    txb = 8'h00;
    bst = 1'b0;
    case (r.opcode)
      OP_TICK: begin
        case (m_mode)
          MODE_SETTLE: begin
            bump_ticks();
            if (m_ticks >= r_settle) begin
              m_mode  = MODE_ASLEEP;
              m_ticks = '0;
            end
          end
          MODE_ASLEEP: begin
            if (r.key_pressed) begin
              m_key_held = 1'b1;
              bump_ticks();
              if (m_ticks >= r_wake) begin
                m_mode     = MODE_ACTIVE;
                m_ticks    = '0;
                m_key_held = 1'b0;
              end
            end else if (m_key_held) begin
              supply_down();
            end
          end
          MODE_ACTIVE: begin
            if (r.key_pressed) begin
              bump_ticks();
              if (m_ticks >= r_off_hold) supply_down();
            end else begin
              m_ticks = '0;
              if (m_chg_req) begin
                m_chg_req = 1'b0;
                txv = 1'b1;
                txb = {7'd0, r.charging};
              end
            end
          end
          MODE_OFFDLY: begin
            bump_ticks();
            if (m_ticks >= r_off_delay) supply_down();
          end
          default: ;
        endcase
        push_out(txv, txb, 1'b0, 1'b1);
      end
      OP_CMD: begin
        if (m_mode == MODE_ACTIVE) begin
          case (r.rx_byte)
            CMD_VOLTAGE: begin
              if (m_burst) begin
                m_volt_req = 1'b1;
              end else begin
                begin_burst();
                bst = 1'b1;
              end
            end
            CMD_CHARGE: m_chg_req = 1'b1;
            CMD_POWEROFF: begin
              if (r_off_delay == 16'd0) begin
                supply_down();
              end else begin
                m_mode  = MODE_OFFDLY;
                m_ticks = '0;
              end
            end
            default: ;
          endcase
        end
        push_out(1'b0, 8'h00, bst, 1'b1);
      end
      OP_SAMPLE: begin
        if (m_burst) begin
          m_scount++;
          if (m_scount > SAMPLES_DROPPED) m_ssum = m_ssum + SUM_W'(r.sample);
        end
        if (m_burst && m_scount >= SAMPLES_BURST) begin
          avg  = m_ssum[SUM_W-1:AVG_SHIFT];
          volt = 16'hffff;
          if (avg != '0) begin
            quo = (32'(r_bandgap) << SCALE_SHIFT) / 32'(avg);
            if (quo < 32'h0000ffff) volt = quo[VOLT_W-1:0];
          end
          m_burst  = 1'b0;
          m_scount = '0;
          m_ssum   = '0;
          again    = m_volt_req;
          if (again) begin
            m_volt_req = 1'b0;
            begin_burst();
          end
          n_volt++;
          push_out(1'b1, volt[15:8], 1'b0, 1'b0);
          push_out(1'b1, volt[7:0], again, 1'b1);
        end else begin
          push_out(1'b0, 8'h00, 1'b0, 1'b1);
        end
      end
      default: push_out(1'b0, 8'h00, 1'b0, 1'b1);
    endcase
  endtask

  // drive at the falling edge, hold until taken at a rising edge
  task automatic send_req(input in_req_t r);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = r;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_supply(r);
    n_sent++;
  endtask

  function automatic in_req_t rand_req(input logic [1:0] op);
    in_req_t r;
    r.opcode      = op;
    r.key_pressed = 1'($urandom_range(0, 1));
    r.charging    = 1'($urandom_range(0, 1));
    r.rx_byte     = 8'($urandom_range(0, 255));
    r.sample      = 10'($urandom_range(0, 1023));
    return r;
  endfunction

  task automatic tick(input logic key, input logic chg);
    in_req_t r;
    r = rand_req(OP_TICK);
    r.key_pressed = key;
    r.charging    = chg;
    send_req(r);
  endtask

  task automatic cmd(input logic [7:0] code);
    in_req_t r;
    r = rand_req(OP_CMD);
    r.rx_byte = code;
    send_req(r);
  endtask

  task automatic sample(input logic [SAMPLE_W-1:0] v);
    in_req_t r;
    r = rand_req(OP_SAMPLE);
    r.sample = v;
    send_req(r);
  endtask

  // drop valid, wait out every pending result and the divider latency
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_out.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      REG_WAKE_HOLD: r_wake      = val;
      REG_OFF_HOLD:  r_off_hold  = val;
      REG_SETTLE:    r_settle    = val;
      REG_OFF_DELAY: r_off_delay = val;
      REG_BANDGAP:   r_bandgap   = val[BANDGAP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic apply_setting(input logic [15:0] wake, input logic [15:0] off_hold,
                               input logic [15:0] settle, input logic [15:0] off_delay,
                               input logic [15:0] bandgap);
    wait_drained();
    write_reg(REG_WAKE_HOLD, wake);
    write_reg(REG_OFF_HOLD, off_hold);
    write_reg(REG_SETTLE, settle);
    write_reg(REG_OFF_DELAY, off_delay);
    write_reg(REG_BANDGAP, bandgap);
    n_settings++;
  endtask

  // mostly well-formed wake, burst and command sequences, some noise
  task automatic run_traffic(input int count);
    in_req_t r;
    int      pick;
    for (int n = 0; n < count; n++) begin
      r    = rand_req(OP_TICK);
      pick = $urandom_range(0, 99);
      if (m_burst && pick < 55) begin
        r.opcode = OP_SAMPLE;
        case (burst_kind)
          1: r.sample = '0;
          2: r.sample = 10'($urandom_range(0, 15));
          3: r.sample = 10'($urandom_range(1000, 1023));
          default: r.sample = 10'($urandom_range(0, 1023));
        endcase
      end else if (m_mode != MODE_ACTIVE) begin
        if (pick < 80) begin
          r.key_pressed = ($urandom_range(0, 99) < 85);
        end else if (pick < 90) begin
          r.opcode = OP_CMD;
          case ($urandom_range(0, 3))
            0: r.rx_byte = CMD_VOLTAGE;
            1: r.rx_byte = CMD_CHARGE;
            2: r.rx_byte = CMD_POWEROFF;
            default: ;
          endcase
        end else begin
          r.opcode = 2'($urandom_range(0, 3));
        end
      end else begin
        if (pick < 30) begin
          r.key_pressed = ($urandom_range(0, 99) < 25);
        end else if (pick < 42) begin
          r.opcode   = OP_CMD;
          r.rx_byte  = CMD_VOLTAGE;
          burst_kind = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 3);
        end else if (pick < 50) begin
          r.opcode  = OP_CMD;
          r.rx_byte = CMD_CHARGE;
        end else if (pick < 53) begin
          r.opcode  = OP_CMD;
          r.rx_byte = CMD_POWEROFF;
        end else if (pick < 60) begin
          r.opcode = OP_CMD;
        end else if (pick < 64) begin
          r.opcode = OP_SPARE;
        end else if (pick < 70) begin
          r.opcode = OP_SAMPLE;
        end else begin
          r.key_pressed = 1'b0;
        end
      end
      send_req(r);
    end
  endtask

  task automatic test_sleep_and_wake();
    apply_setting(16'd2, 16'd3, 16'd1, 16'd2, 16'd4095);
    tick(1'b0, 1'b0);
    cmd(CMD_VOLTAGE);
    tick(1'b1, 1'b0);
    tick(1'b0, 1'b0);
    tick(1'b0, 1'b0);
    tick(1'b1, 1'b0);
    tick(1'b1, 1'b0);
    sample(10'd512);
    send_req(rand_req(OP_SPARE));
    cmd(CMD_UNKNOWN);
  endtask

  task automatic test_voltage_reply();
    cmd(CMD_VOLTAGE);
    cmd(CMD_VOLTAGE);
    repeat (2) sample(10'd0);
    repeat (8) sample(10'd1023);
    repeat (2) sample(10'd1023);
    repeat (8) sample(10'd0);
  endtask

  task automatic test_charge_and_remote_off();
    cmd(CMD_CHARGE);
    tick(1'b1, 1'b1);
    tick(1'b0, 1'b1);
    cmd(CMD_CHARGE);
    cmd(CMD_VOLTAGE);
    cmd(CMD_POWEROFF);
    cmd(CMD_CHARGE);
    cmd(CMD_VOLTAGE);
    repeat (10) sample(10'($urandom_range(0, 1023)));
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
  endtask

  task automatic test_key_power_off();
    apply_setting(16'd1, 16'd3, 16'd0, 16'd0, 16'd1190);
    tick(1'b1, 1'b0);
    repeat (3) tick(1'b1, 1'b0);
    tick(1'b1, 1'b0);
    cmd(CMD_CHARGE);
    tick(1'b0, 1'b0);
    cmd(CMD_POWEROFF);
    tick(1'b0, 1'b0);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_setting(16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
        1: apply_setting(16'd2, 16'd5, 16'd1, 16'd3, 16'hffff);
        default: apply_setting(16'($urandom_range(1, 6)), 16'($urandom_range(2, 12)),
                               16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)),
                               16'($urandom_range(0, 65535)));
      endcase
      steady = (ph == 3);
      run_traffic(230);
    end
    steady = 1'b0;
  endtask

  task automatic test_register_extremes();
    apply_setting(16'd1, 16'd12, 16'd0, 16'd6, 16'd1190);
    run_traffic(40);
    apply_setting(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    run_traffic(60);
    wait_drained();
    write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
    apply_setting(16'd3, 16'd8, 16'd2, 16'd4, 16'd2048);
    run_traffic(60);
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      n_err++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  always @(negedge clk) out_ready = steady || ($urandom_range(0, 99) >= 25);

  always @(posedge clk) begin : check_out
    out_req_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (due_out.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result: expected none, actual %p", $time, out_data);
      end else begin
        want = due_out.pop_front();
        check_field("power_enable", want.power_enable, out_data.power_enable);
        check_field("tx_valid", want.tx_valid, out_data.tx_valid);
        check_field("tx_byte", want.tx_byte, out_data.tx_byte);
        check_field("adc_burst_start", want.adc_burst_start, out_data.adc_burst_start);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, due_out.size());
      $display("tb_power_button_supply_controller NOT OK");
      $finish;
    end
  end

  initial begin
    r_wake      = WAKE_HOLD_RST;
    r_off_hold  = OFF_HOLD_RST;
    r_settle    = SETTLE_RST;
    r_off_delay = OFF_DELAY_RST;
    r_bandgap   = BANDGAP_RST;
    supply_down();
    m_mode = MODE_SETTLE;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_sleep_and_wake();
    test_voltage_reply();
    test_charge_and_remote_off();
    test_key_power_off();
    test_random_traffic();
    test_register_extremes();
    wait_drained();

    $display("Run: %0d requests, %0d results, %0d voltage replies, %0d register settings",
             n_sent, n_results, n_volt, n_settings);
    $display("Covered wake and release, key and remote power-off, charge queries, bursts");
    if (n_err == 0) begin
      $display("tb_power_button_supply_controller OK");
    end else begin
      $display("tb_power_button_supply_controller NOT OK");
    end
    $finish;
  end

endmodule
